FILE: sv/rgd_pkg.sv
// Shared types and constants for the repeated group decoder.
// Used by the count unit, the top level and the port checker; no dependencies.
`timescale 1ns / 1ps

package rgd_pkg;

    // Width of the running decoded-byte count.
    localparam int RGD_COUNT_BITS = 24;
    // Width of the picture size register.
    localparam int RGD_CFG_W = 24;
    // Largest group length in bytes.
    localparam int RGD_GROUP_MAX = 15;
    // Output data beat: 64 + 56 + 4 bits, padded to 128.
    localparam int RGD_TDATA_W = 128;
    localparam int RGD_LEN_LSB = 120;

    localparam logic [RGD_CFG_W-1:0] RGD_PIC_BYTES_RESET = 24'd115200;

    // Decoder sequencer states.
    typedef enum logic [1:0] {
        ST_HEADER,
        ST_LITERAL,
        ST_EMIT
    } rgd_state_t;

    // Result of one pass through the count unit.
    typedef struct packed {
        logic [RGD_COUNT_BITS-1:0] total;
        logic                      done;
    } rgd_count_res_t;

endpackage

FILE: sv/rgd_count_unit.sv
// Shared add-and-compare unit that advances the decoded-byte count by one group copy.
// Depends on rgd_pkg.
`timescale 1ns / 1ps

module rgd_count_unit
    import rgd_pkg::*;
(
    input  logic [RGD_COUNT_BITS-1:0] total,
    input  logic [3:0]                group_len,
    input  logic [RGD_CFG_W-1:0]      picture_bytes,
    output rgd_count_res_t            res
);

    logic [RGD_COUNT_BITS:0] sum_wide;
    logic [RGD_COUNT_BITS:0] pic_wide;
    logic                    reach;
    logic                    overflow;

    // Add the group length with one guard bit for overflow.
    assign sum_wide = {1'b0, total} + (RGD_COUNT_BITS + 1)'(group_len);
    assign pic_wide = (RGD_COUNT_BITS + 1)'(picture_bytes);

    // The picture is complete when the total is reached or the count overflows.
    assign reach    = (sum_wide >= pic_wide);
    assign overflow = sum_wide[RGD_COUNT_BITS];

    always_comb
    begin
        res.done  = reach | overflow;
        res.total = (reach | overflow) ? '0 : sum_wide[RGD_COUNT_BITS-1:0];
    end

endmodule

FILE: sv/repeated_group_decoder_top.sv
// Top level of the repeated group decoder: header/literal sequencer, literal store,
// output register. Depends on rgd_pkg and rgd_count_unit.
`timescale 1ns / 1ps

// Usage:
// The slave stream carries one compressed byte per beat. A header byte gives the
// group length in its high nibble and the repeat count in its low nibble; that many
// literal bytes follow. After the last literal of a group with a nonzero repeat
// count the block enters its emit state, drops s_axis_tready and emits the group
// once per repeat on the master stream, one copy per cycle while m_axis_tready is
// high, so the input is held until the last copy is loaded. tlast marks the final
// copy and tuser marks the copy on which the decoded byte count reached the picture
// size; the count then restarts. A single add-and-compare unit updates the count
// once per copy, which sets the copy rate. The master side has an output register,
// so a stalled receiver holds the current copy and the sequencer waits. The picture
// size must be written through cfg_wen/cfg_wdata only while the block is idle; the
// block itself does not enforce this. Reset (rst_n low) returns the sequencer to
// expecting a header, clears the count and sets the picture size to 115200.
module repeated_group_decoder_top
    import rgd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Picture size register write port.
    input  logic                   cfg_wen,
    input  logic [RGD_CFG_W-1:0]   cfg_wdata,
    // Compressed byte stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] code_byte
    // Decoded group copies.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [RGD_TDATA_W-1:0] m_axis_tdata,   // [63:0] group_low, [119:64] group_high,
                                                   // [123:120] group_length, [127:124] zero
    output logic                   m_axis_tlast,   // last_copy
    output logic                   m_axis_tuser    // [0] picture_done
);

    rgd_state_t                state_reg, state_next;
    logic [3:0]                len_reg, len_next;
    logic [3:0]                rep_reg, rep_next;
    logic [3:0]                lit_cnt_reg, lit_cnt_next;
    logic [3:0]                copy_reg, copy_next;
    logic [RGD_COUNT_BITS-1:0] total_reg, total_next;
    logic [RGD_CFG_W-1:0]      pic_bytes_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [RGD_TDATA_W-1:0]    out_data_reg;
    logic                      out_last_reg;
    logic                      out_done_reg;
    logic [7:0]                lit_store_reg [RGD_GROUP_MAX];

    logic                      in_beat;
    logic                      out_free;
    logic                      store_we;
    logic                      load;
    logic                      copy_last;
    logic [4:0]                lit_cnt_inc;
    logic [RGD_TDATA_W-1:0]    packed_data;
    rgd_count_res_t            cu_res;

    assign s_axis_tready = (state_reg != ST_EMIT);
    assign in_beat       = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~out_valid_reg | m_axis_tready;
    assign lit_cnt_inc   = {1'b0, lit_cnt_reg} + 5'd1;
    assign copy_last     = ((copy_reg + 4'd1) == rep_reg);

    // Shared count unit, used once for every emitted copy.
    rgd_count_unit u_count (
        .total         (total_reg),
        .group_len     (len_reg),
        .picture_bytes (pic_bytes_reg),
        .res           (cu_res)
    );

    // Pack the group bytes; positions past the group length read as zero.
    always_comb
    begin
        packed_data = '0;
        for (int i = 0; i < RGD_GROUP_MAX; i++)
        begin
            if (4'(i) < len_reg)
            begin
                packed_data[8*i +: 8] = lit_store_reg[i];
            end
        end
        packed_data[RGD_LEN_LSB +: 4] = len_reg;
    end

    // Sequencer: next state and counters.
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        rep_next       = rep_reg;
        lit_cnt_next   = lit_cnt_reg;
        copy_next      = copy_reg;
        total_next     = total_reg;
        store_we       = 1'b0;
        load           = 1'b0;
        case (state_reg)
            ST_HEADER:
            begin
                if (in_beat)
                begin
                    len_next     = s_axis_tdata[7:4];
                    rep_next     = s_axis_tdata[3:0];
                    lit_cnt_next = '0;
                    if (s_axis_tdata[7:4] != 4'd0)
                    begin
                        state_next = ST_LITERAL;
                    end
                end
            end
            ST_LITERAL:
            begin
                if (in_beat)
                begin
                    store_we     = 1'b1;
                    lit_cnt_next = lit_cnt_inc[3:0];
                    if (lit_cnt_inc >= {1'b0, len_reg})
                    begin
                        lit_cnt_next = '0;
                        copy_next    = '0;
                        state_next   = (rep_reg != 4'd0) ? ST_EMIT : ST_HEADER;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    total_next = cu_res.total;
                    copy_next  = copy_reg + 4'd1;
                    if (copy_last)
                    begin
                        state_next = ST_HEADER;
                    end
                end
            end
            default:
            begin
                state_next = ST_HEADER;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HEADER;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers and the picture size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            rep_reg       <= '0;
            lit_cnt_reg   <= '0;
            copy_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            pic_bytes_reg <= RGD_PIC_BYTES_RESET;
        end
        else
        begin
            len_reg       <= len_next;
            rep_reg       <= rep_next;
            lit_cnt_reg   <= lit_cnt_next;
            copy_reg      <= copy_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                pic_bytes_reg <= cfg_wdata;
            end
        end
    end

    // Literal store, written at the current literal position.
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            lit_store_reg[lit_cnt_reg] <= s_axis_tdata;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= packed_data;
            out_last_reg <= copy_last;
            out_done_reg <= cu_res.done;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_done_reg;

endmodule

FILE: sv/rgd_checker.sv
// Port-level checker for the repeated group decoder and its bind to the top level.
// Depends on rgd_pkg and repeated_group_decoder_top.
`timescale 1ns / 1ps

module rgd_checker
    import rgd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [RGD_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast,
    input logic                   m_axis_tuser
);

    // A stalled copy keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    // Every emitted copy has a nonzero group length.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[RGD_LEN_LSB +: 4] != 4'd0)
        else $error("output beat with zero group length");

    // A short group leaves the top byte position zero, and the pad bits are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[127:124] == 4'd0)
            && ((m_axis_tdata[RGD_LEN_LSB +: 4] == 4'd15) || (m_axis_tdata[119:112] == 8'd0)))
        else $error("bytes beyond group length are not zero");

    // While copies of a group remain to be sent, no input beat is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken during a repeat burst");

endmodule

bind repeated_group_decoder_top rgd_checker u_rgd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: bench/tb_top.sv
// Self-checking testbench for repeated_group_decoder_top: drives header and literal
// beats, predicts every group copy and checks the master stream against it.
// Depends on rgd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
    import rgd_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOW_MAX    = 10;

    // One expected group copy on the master stream.
    typedef struct packed {
        logic [63:0] group_low;
        logic [55:0] group_high;
        logic [3:0]  group_length;
        logic        last_copy;
        logic        picture_done;
    } group_copy_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wen = 1'b0;
    logic [RGD_CFG_W-1:0]   cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [RGD_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    // Predictor state: decoder sequencing, literal bytes and the picture count.
    logic                      in_literals;
    logic [3:0]                grp_len;
    logic [3:0]                grp_repeat;
    logic [7:0]                lit_bytes [RGD_GROUP_MAX];
    logic [3:0]                lit_count;
    logic [RGD_COUNT_BITS-1:0] pic_count;
    logic [RGD_CFG_W-1:0]      pic_size;

    group_copy_t pending_copies [$];

    bit idle_en = 1'b1;
    int stall_left = 0;
    int cycles = 0;
    int mismatches = 0;
    int bytes_sent = 0;
    int copies_seen = 0;
    int done_seen = 0;
    int sizes_written = 0;

    repeated_group_decoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast),
        .m_axis_tuser  (m_tuser)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_top: timeout after %0d cycles, %0d copies still awaited",
                     cycles, pending_copies.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Receiver back-pressure: random stall bursts, none while idling is off.
    always @(posedge clk)
    begin
        if (!idle_en)
        begin
            m_tready <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 16);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Compare every accepted output beat with the oldest predicted copy.
    always @(posedge clk)
    begin : check_copies
        group_copy_t want;
        group_copy_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[63:0], m_tdata[119:64], m_tdata[123:120], m_tlast, m_tuser};
            copies_seen++;
            if (m_tuser)
                done_seen++;
            if (pending_copies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("tb_top: unexpected copy at cycle %0d: data %h last %b done %b",
                             cycles, m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                want = pending_copies.pop_front();
                if (got != want || m_tdata[127:124] != 4'h0)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                    begin
                        $display("tb_top: copy mismatch at cycle %0d", cycles);
                        $display("  expected low %h high %h len %0d last %b done %b",
                                 want.group_low, want.group_high, want.group_length,
                                 want.last_copy, want.picture_done);
                        $display("  actual   low %h high %h len %0d last %b done %b pad %h",
                                 got.group_low, got.group_high, got.group_length,
                                 got.last_copy, got.picture_done, m_tdata[127:124]);
                    end
                end
            end
        end
    end

    // Emit the completed group once per repeat and advance the picture count.
    task automatic emit_copies();
        group_copy_t copy;
        logic [RGD_COUNT_BITS:0] sum;
        copy = '0;
        for (int i = 0; i < grp_len; i++)
        begin
            if (i < 8)
                copy.group_low[8*i +: 8] = lit_bytes[i];
            else
                copy.group_high[8*(i-8) +: 8] = lit_bytes[i];
        end
        copy.group_length = grp_len;
        for (int i = 0; i < grp_repeat; i++)
        begin
            sum = {1'b0, pic_count} + grp_len;
            copy.picture_done = (sum >= {1'b0, pic_size}) || sum[RGD_COUNT_BITS];
            if (copy.picture_done)
                sum = '0;
            pic_count = sum[RGD_COUNT_BITS-1:0];
            copy.last_copy = (i + 1 == grp_repeat);
            pending_copies.push_back(copy);
        end
    endtask

    // Predictor step for one accepted code byte.
    task automatic decode_code_byte(input logic [7:0] code);
        if (!in_literals)
        begin
            grp_len = code[7:4];
            grp_repeat = code[3:0];
            lit_count = '0;
            in_literals = (grp_len != 0);
        end
        else
        begin
            lit_bytes[lit_count] = code;
            lit_count = lit_count + 1'b1;
            if (lit_count >= grp_len)
            begin
                in_literals = 1'b0;
                lit_count = '0;
                emit_copies();
            end
        end
    endtask

    // Send one code byte, with an occasional idle burst ahead of it.
    task automatic send_code(input logic [7:0] code);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 17);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= code;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        decode_code_byte(code);
    endtask

    // Stop the input and let every predicted copy drain out.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_copies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_picture_size(input logic [RGD_CFG_W-1:0] size);
        wait_idle();
        cfg_wen <= 1'b1;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_wen <= 1'b0;
        pic_size = size;
        sizes_written++;
    endtask

    // Random stream: mostly well-formed groups, some empty headers and stray bytes.
    task automatic send_stream(input int n_items);
        int start;
        int kind;
        int len;
        int rpt;
        start = bytes_sent;
        while (bytes_sent - start < n_items)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                send_code(8'($urandom_range(0, 255)));
            end
            else if (kind == 1)
            begin
                send_code({4'h0, 4'($urandom_range(0, 15))});
            end
            else
            begin
                len = $urandom_range(1, RGD_GROUP_MAX);
                rpt = $urandom_range(0, 15);
                send_code({len[3:0], rpt[3:0]});
                repeat (len) send_code(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Empty groups, zero repeats, the longest group and literal extremes,
    // all at the picture size left by reset.
    task automatic test_special_headers();
        send_code(8'h00);
        send_code(8'h0F);
        send_code(8'h30);
        send_code(8'hAA);
        send_code(8'h55);
        send_code(8'h01);
        send_code(8'h11);
        send_code(8'h00);
        send_code(8'hFF);
        for (int i = 0; i < RGD_GROUP_MAX; i++)
            send_code((i % 2 == 0) ? 8'hFF : 8'h00);
        send_code(8'h21);
        send_code(8'h80);
        send_code(8'h7F);
    endtask

    // Smallest, zero and largest picture sizes.
    task automatic test_size_extremes();
        set_picture_size(24'd1);
        send_stream(40);
        set_picture_size(24'd0);
        send_stream(40);
        set_picture_size({RGD_CFG_W{1'b1}});
        send_stream(40);
    endtask

    // Sizes small enough that several pictures complete per phase, then the reset size again.
    task automatic test_random_sizes();
        for (int i = 0; i < 3; i++)
        begin
            set_picture_size(RGD_CFG_W'($urandom_range(2, 400)));
            send_stream(60);
        end
        set_picture_size(RGD_PIC_BYTES_RESET);
        send_stream(40);
    endtask

    // Final stretch with both sides running flat out.
    task automatic test_full_rate();
        set_picture_size(RGD_CFG_W'($urandom_range(20, 200)));
        idle_en = 1'b0;
        send_stream(60);
    endtask

    initial
    begin
        in_literals = 1'b0;
        grp_len = '0;
        grp_repeat = '0;
        lit_count = '0;
        pic_count = '0;
        pic_size = RGD_PIC_BYTES_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_headers();
        test_size_extremes();
        test_random_sizes();
        test_full_rate();

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        $display("tb_top: %0d code bytes sent, %0d group copies checked, %0d ended a picture",
                 bytes_sent, copies_seen, done_seen);
        $display("tb_top: %0d picture sizes written, %0d mismatches",
                 sizes_written, mismatches);
        if (mismatches == 0 && pending_copies.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
